### hdl/rational_arithmetic_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication
`define RAU_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RAU_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/rau_pkg.sv
// Types, codes and widths of the rational arithmetic unit.
package rau_pkg;

   localparam int OPERAND_WIDTH = 32;
   localparam int PW            = 2 * OPERAND_WIDTH;
   localparam int SHW           = $clog2(PW);
   localparam int NUM_W         = 32;
   localparam int DEN_W         = 31;

   localparam logic [OPERAND_WIDTH-1:0] LIMIT_M1 = {1'b0, {(OPERAND_WIDTH-1){1'b1}}};

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_CMP = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ZERO_DEN = 2'd1;
   localparam logic [1:0] ST_DIV_ZERO = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   localparam logic [2:0] RES_VALUE    = 3'd0;
   localparam logic [2:0] RES_ZERO     = 3'd1;
   localparam logic [2:0] RES_ZERO_DEN = 3'd2;
   localparam logic [2:0] RES_DIV_ZERO = 3'd3;
   localparam logic [2:0] RES_CMP      = 3'd4;

   localparam logic [1:0] MSEL_NUM   = 2'd0;
   localparam logic [1:0] MSEL_CROSS = 2'd1;
   localparam logic [1:0] MSEL_DEN   = 2'd2;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] a_num;
      logic signed [31:0] a_den;
      logic signed [31:0] b_num;
      logic signed [31:0] b_den;
   } req_type;

   typedef struct packed {
      logic signed [NUM_W-1:0] res_num;
      logic [DEN_W-1:0]        res_den;
      logic                    less;
      logic [1:0]              status;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       mul_en;
      logic [1:0] mul_sel;
      logic       sum_en;
      logic       gcd_init;
      logic       gcd_step;
      logic       div_init;
      logic       div_step;
      logic       out_load;
      logic [2:0] res_code;
   } cmd_type;

   typedef struct packed {
      logic zero_den;
      logic div_zero;
      logic bad_op;
      logic is_cmp;
      logic num_zero;
      logic gcd_done;
      logic div_last;
      logic out_free;
   } stat_type;

endpackage

### hdl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_data (rau_pkg::req_type)
//   rsp      out        rsp_valid / rsp_ready  rsp_data (rau_pkg::rsp_type)
//
// One transaction at a time: numerator, cross and denominator multiplies, sum and check,
// then a binary gcd and a shift-subtract division of numerator and denominator by it.
// Errors, compare and zero results skip the gcd and division.
// Reset is synchronous; a result held by rsp_ready low does not stop the next request.
module rational_arithmetic_unit import rau_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type  cmd;
   stat_type stat;

   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rau_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### hdl/rau_ctrl.sv
// Sequencer of the rational arithmetic unit.
module rau_ctrl import rau_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MUL_N = 4'd1;
   localparam logic [3:0] S_MUL_C = 4'd2;
   localparam logic [3:0] S_MUL_D = 4'd3;
   localparam logic [3:0] S_SUM   = 4'd4;
   localparam logic [3:0] S_CHECK = 4'd5;
   localparam logic [3:0] S_GCD   = 4'd6;
   localparam logic [3:0] S_DIV   = 4'd7;
   localparam logic [3:0] S_FIN   = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [2:0] code_ff, code_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      cmd      = '0;
      cmd.res_code = code_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MUL_N;
            end
         end
         S_MUL_N: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MSEL_NUM;
            state_in    = S_MUL_C;
         end
         S_MUL_C: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MSEL_CROSS;
            state_in    = S_MUL_D;
         end
         S_MUL_D: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MSEL_DEN;
            state_in    = S_SUM;
         end
         S_SUM: begin
            cmd.sum_en = 1'b1;
            state_in   = S_CHECK;
         end
         S_CHECK: begin
            state_in = S_FIN;
            if (stat.zero_den) begin
               code_in = RES_ZERO_DEN;
            end else if (stat.bad_op) begin
               code_in = RES_ZERO;
            end else if (stat.div_zero) begin
               code_in = RES_DIV_ZERO;
            end else if (stat.is_cmp) begin
               code_in = RES_CMP;
            end else if (stat.num_zero) begin
               code_in = RES_ZERO;
            end else begin
               cmd.gcd_init = 1'b1;
               state_in     = S_GCD;
            end
         end
         S_GCD: begin
            if (stat.gcd_done) begin
               cmd.div_init = 1'b1;
               state_in     = S_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               code_in  = RES_VALUE;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= RES_ZERO;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

endmodule

### hdl/rau_dp.sv
// Datapath: operand registers, shared multiplier, adder, binary gcd and dividers.
module rau_dp import rau_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  cmd_type  cmd,
   output stat_type stat,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   localparam int W = OPERAND_WIDTH;

   logic [2:0]   op_ff;
   logic [W-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic         an_neg_ff, ad_neg_ff, bn_neg_ff, bd_neg_ff;
   logic [PW-1:0] p_num_ff, p_cross_ff, p_den_ff;
   logic [PW-1:0] num_ff, num_in;
   logic          neg_ff, neg_in;
   logic [PW-1:0] gx_ff, gx_in, gy_ff, gy_in;
   logic [SHW-1:0] k_ff, k_in;
   logic [PW-1:0] g_ff;
   logic [PW-1:0] qn_ff, qn_in, qd_ff, qd_in, rn_ff, rn_in, rd_ff, rd_in;
   logic [SHW-1:0] cnt_ff;
   logic          valid_ff, valid_in;
   rsp_type       out_ff, out_in;

   logic [W-1:0]  raw_an, raw_ad, raw_bn, raw_bd;
   logic [W-1:0]  mul_a, mul_b;
   logic [PW-1:0] product;
   logic          an_s, bn_s, s1, s2, muldiv;
   logic [PW:0]   tn, td;
   logic [PW-1:0] neg_val;
   logic          ovf;

   assign raw_an = req_data.a_num[W-1:0];
   assign raw_ad = req_data.a_den[W-1:0];
   assign raw_bn = req_data.b_num[W-1:0];
   assign raw_bd = req_data.b_den[W-1:0];

   assign muldiv = (op_ff == OP_MUL) || (op_ff == OP_DIV);
   assign an_s   = an_neg_ff ^ ad_neg_ff;
   assign bn_s   = bn_neg_ff ^ bd_neg_ff;
   assign s1     = muldiv ? (an_s ^ bn_s) : an_s;
   assign s2     = bn_s ^ (op_ff != OP_ADD);

   always_comb begin
      mul_a = an_ff;
      mul_b = bd_ff;
      case (cmd.mul_sel)
         MSEL_NUM: begin
            mul_a = an_ff;
            mul_b = (op_ff == OP_MUL) ? bn_ff : bd_ff;
         end
         MSEL_CROSS: begin
            mul_a = bn_ff;
            mul_b = ad_ff;
         end
         default: begin
            mul_a = ad_ff;
            mul_b = (op_ff == OP_DIV) ? bn_ff : bd_ff;
         end
      endcase
   end

   assign product = PW'(mul_a) * PW'(mul_b);

   always_comb begin
      num_in = num_ff;
      neg_in = neg_ff;
      if (cmd.sum_en) begin
         if (muldiv) begin
            num_in = p_num_ff;
            neg_in = s1;
         end else if (s1 == s2) begin
            num_in = p_num_ff + p_cross_ff;
            neg_in = s1;
         end else if (p_num_ff >= p_cross_ff) begin
            num_in = p_num_ff - p_cross_ff;
            neg_in = s1;
         end else begin
            num_in = p_cross_ff - p_num_ff;
            neg_in = s2;
         end
         if (num_in == '0) begin
            neg_in = 1'b0;
         end
      end
   end

   always_comb begin
      gx_in = gx_ff;
      gy_in = gy_ff;
      k_in  = k_ff;
      if (cmd.gcd_init) begin
         gx_in = num_ff;
         gy_in = p_den_ff;
         k_in  = '0;
      end else if (cmd.gcd_step) begin
         if (!gx_ff[0] && !gy_ff[0]) begin
            gx_in = gx_ff >> 1;
            gy_in = gy_ff >> 1;
            k_in  = k_ff + 1'b1;
         end else if (!gx_ff[0]) begin
            gx_in = gx_ff >> 1;
         end else if (!gy_ff[0]) begin
            gy_in = gy_ff >> 1;
         end else if (gx_ff >= gy_ff) begin
            gx_in = (gx_ff - gy_ff) >> 1;
         end else begin
            gy_in = (gy_ff - gx_ff) >> 1;
         end
      end
   end

   assign tn = {rn_ff, qn_ff[PW-1]};
   assign td = {rd_ff, qd_ff[PW-1]};

   always_comb begin
      qn_in = qn_ff;
      qd_in = qd_ff;
      rn_in = rn_ff;
      rd_in = rd_ff;
      if (cmd.div_init) begin
         qn_in = num_ff;
         qd_in = p_den_ff;
         rn_in = '0;
         rd_in = '0;
      end else if (cmd.div_step) begin
         if (tn >= {1'b0, g_ff}) begin
            rn_in = PW'(tn - {1'b0, g_ff});
            qn_in = {qn_ff[PW-2:0], 1'b1};
         end else begin
            rn_in = tn[PW-1:0];
            qn_in = {qn_ff[PW-2:0], 1'b0};
         end
         if (td >= {1'b0, g_ff}) begin
            rd_in = PW'(td - {1'b0, g_ff});
            qd_in = {qd_ff[PW-2:0], 1'b1};
         end else begin
            rd_in = td[PW-1:0];
            qd_in = {qd_ff[PW-2:0], 1'b0};
         end
      end
   end

   assign neg_val = neg_ff ? (~qn_ff + 1'b1) : qn_ff;
   assign ovf = (qd_ff > PW'(LIMIT_M1)) ||
                (qn_ff > (PW'(LIMIT_M1) + PW'(neg_ff)));

   always_comb begin
      out_in         = out_ff;
      valid_in       = valid_ff && !rsp_ready;
      if (cmd.out_load) begin
         valid_in       = 1'b1;
         out_in.res_num = '0;
         out_in.res_den = DEN_W'(1);
         out_in.less    = 1'b0;
         out_in.status  = ST_OK;
         unique case (cmd.res_code)
            RES_VALUE: begin
               if (ovf) begin
                  out_in.status = ST_OVERFLOW;
               end else begin
                  out_in.res_num = NUM_W'(signed'(neg_val[W-1:0]));
                  out_in.res_den = DEN_W'(qd_ff[W-2:0]);
               end
            end
            RES_ZERO_DEN: out_in.status = ST_ZERO_DEN;
            RES_DIV_ZERO: out_in.status = ST_DIV_ZERO;
            RES_CMP:      out_in.less   = neg_ff;
            default:      out_in.status = ST_OK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_data.op;
         an_neg_ff <= raw_an[W-1];
         ad_neg_ff <= raw_ad[W-1];
         bn_neg_ff <= raw_bn[W-1];
         bd_neg_ff <= raw_bd[W-1];
         an_ff     <= raw_an[W-1] ? (~raw_an + 1'b1) : raw_an;
         ad_ff     <= raw_ad[W-1] ? (~raw_ad + 1'b1) : raw_ad;
         bn_ff     <= raw_bn[W-1] ? (~raw_bn + 1'b1) : raw_bn;
         bd_ff     <= raw_bd[W-1] ? (~raw_bd + 1'b1) : raw_bd;
      end
      if (cmd.mul_en) begin
         case (cmd.mul_sel)
            MSEL_NUM:   p_num_ff   <= product;
            MSEL_CROSS: p_cross_ff <= product;
            default:    p_den_ff   <= product;
         endcase
      end
      if (cmd.div_init) begin
         g_ff <= (gx_ff | gy_ff) << k_ff;
      end
      num_ff <= num_in;
      neg_ff <= neg_in;
      gx_ff  <= gx_in;
      gy_ff  <= gy_in;
      k_ff   <= k_in;
      qn_ff  <= qn_in;
      qd_ff  <= qd_in;
      rn_ff  <= rn_in;
      rd_ff  <= rd_in;
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         if (cmd.div_init) begin
            cnt_ff <= '0;
         end else if (cmd.div_step) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   assign stat.zero_den = (ad_ff == '0) || (bd_ff == '0);
   assign stat.div_zero = (op_ff == OP_DIV) && (bn_ff == '0);
   assign stat.bad_op   = (op_ff > OP_CMP);
   assign stat.is_cmp   = (op_ff == OP_CMP);
   assign stat.num_zero = (num_ff == '0);
   assign stat.gcd_done = (gx_ff == '0) || (gy_ff == '0);
   assign stat.div_last = (cnt_ff == SHW'(PW - 1));
   assign stat.out_free = !valid_ff || rsp_ready;

   assign rsp_valid = valid_ff;
   assign rsp_data  = out_ff;

endmodule

### hdl/rau_checker.sv
// Port-level checker of the rational arithmetic unit and its binding.
`include "rational_arithmetic_unit_assert.svh"

module rau_checker import rau_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   `RAU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped")
   `RAU_ASSERT_NEXT(a_one_txn, req_valid && req_ready, !req_ready, "second transaction taken")
   `RAU_ASSERT_NOW(a_err_clean, rsp_valid && (rsp_data.status != ST_OK), (rsp_data.res_num == 0) && (rsp_data.res_den == 1) && !rsp_data.less, "error result not cleared")
   `RAU_ASSERT_NOW(a_less_clean, rsp_valid && rsp_data.less, (rsp_data.status == ST_OK) && (rsp_data.res_num == 0) && (rsp_data.res_den == 1), "compare result malformed")
   `RAU_ASSERT_NOW(a_den_pos, rsp_valid, rsp_data.res_den != 0, "zero denominator out")

endmodule

bind rational_arithmetic_unit rau_checker u_chk (.*);

### dv/tb_rational_arithmetic_unit.sv
// Testbench of the rational arithmetic unit: directed and random fractions against a predictor.
module tb_rational_arithmetic_unit;
   import rau_pkg::*;

   localparam int MAX_CYCLES = 1000000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int      errors;
   int      cycles;
   int      n_checked;
   int      n_status[4];
   int      req_gap;
   int      rsp_gap;
   int      hold_off;
   bit      stim_done;

   rational_arithmetic_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] magnitude(logic [31:0] v);
      return v[31] ? {32'd0, -v} : {32'd0, v};
   endfunction

   function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
      logic [63:0] t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   // signed-magnitude add on 64-bit magnitudes
   function automatic void sm_add(input bit xn, input logic [63:0] xm, input bit yn,
                                  input logic [63:0] ym, output bit rn,
                                  output logic [63:0] rm);
      if (xn == yn) begin
         rm = xm + ym;
         rn = xn;
      end else if (xm >= ym) begin
         rm = xm - ym;
         rn = xn;
      end else begin
         rm = ym - xm;
         rn = yn;
      end
      if (rm == 0) rn = 1'b0;
   endfunction

   function automatic rsp_type rational_result(req_type r);
      rsp_type     o;
      logic [63:0] anm, adm, bnm, bdm, pm, qm, nm, dm, g;
      bit          ann, bnn, pn, qn, nn;
      o = '{res_num: '0, res_den: 31'd1, less: 1'b0, status: ST_OK};
      anm = magnitude(r.a_num);
      adm = magnitude(r.a_den);
      bnm = magnitude(r.b_num);
      bdm = magnitude(r.b_den);
      if (adm == 0 || bdm == 0) begin
         o.status = ST_ZERO_DEN;
         return o;
      end
      ann = (anm != 0) && (r.a_num[31] != r.a_den[31]);
      bnn = (bnm != 0) && (r.b_num[31] != r.b_den[31]);
      case (r.op) inside
         OP_ADD, OP_SUB, OP_CMP: begin
            pm = anm * bdm;
            pn = (pm != 0) && ann;
            qm = bnm * adm;
            qn = (qm != 0) && (bnn ^ (r.op != OP_ADD));
            sm_add(pn, pm, qn, qm, nn, nm);
            dm = adm * bdm;
            if (r.op == OP_CMP) begin
               o.less = nn;
               return o;
            end
         end
         OP_MUL: begin
            nm = anm * bnm;
            nn = (nm != 0) && (ann != bnn);
            dm = adm * bdm;
         end
         OP_DIV: begin
            if (bnm == 0) begin
               o.status = ST_DIV_ZERO;
               return o;
            end
            nm = anm * bdm;
            nn = (nm != 0) && (ann != bnn);
            dm = adm * bnm;
         end
         default: return o;
      endcase
      if (nm == 0) return o;
      g = gcd64(nm, dm);
      nm = nm / g;
      dm = dm / g;
      if (dm > 64'h7FFF_FFFF || nm > (nn ? 64'h8000_0000 : 64'h7FFF_FFFF)) begin
         o.status = ST_OVERFLOW;
         return o;
      end
      o.res_num = nn ? -nm[31:0] : nm[31:0];
      o.res_den = dm[30:0];
      return o;
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'($signed($urandom_range(0, 8)) - 4);
         3: return 32'($urandom_range(0, 200)) * (32'($urandom_range(0, 1)) * 2 - 1);
         4: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1;
         5: return 32'd0;
         6: return 32'($urandom_range(1, 65535)) << $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_item(logic [2:0] op, logic [31:0] an, logic [31:0] ad,
                             logic [31:0] bn, logic [31:0] bd);
      pending_reqs.push_back('{op: op, a_num: an, a_den: ad, b_num: bn, b_den: bd});
   endtask

   initial begin
      logic [31:0] den_a, den_b;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      errors = 0;
      n_checked = 0;
      stim_done = 1'b0;
      for (int s = 0; s < 4; s++) n_status[s] = 0;
      queue_item(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
      queue_item(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
      queue_item(OP_MUL, -32'd3, 32'd4, 32'd2, -32'd9);
      queue_item(OP_DIV, 32'd5, 32'd7, -32'd10, 32'd21);
      queue_item(OP_CMP, 32'd1, 32'd3, 32'd1, 32'd2);
      queue_item(OP_CMP, 32'd1, 32'd2, 32'd1, 32'd3);
      queue_item(OP_CMP, 32'd2, 32'd4, 32'd1, 32'd2);
      queue_item(OP_ADD, 32'd1, 32'd0, 32'd1, 32'd2);
      queue_item(OP_DIV, 32'd1, 32'd2, 32'd1, 32'd0);
      queue_item(OP_DIV, 32'd1, 32'd2, 32'd0, 32'd5);
      queue_item(OP_MUL, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 32'd1);
      queue_item(OP_MUL, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
      queue_item(OP_ADD, 32'h7FFF_FFFF, 32'd1, 32'd1, 32'd1);
      queue_item(OP_ADD, 32'h8000_0000, 32'd1, 32'hFFFF_FFFF, 32'd1);
      queue_item(OP_MUL, 32'd1, 32'h7FFF_FFFF, 32'd1, 32'd2);
      queue_item(OP_DIV, 32'd1, 32'h8000_0000, 32'd1, 32'd1);
      queue_item(OP_MUL, 32'd0, 32'hFFFF_FFFF, 32'd5, 32'd3);
      queue_item(3'd5, 32'd1, 32'd2, 32'd3, 32'd4);
      queue_item(3'd6, 32'd1, 32'd0, 32'd3, 32'd4);
      queue_item(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_item(OP_SUB, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_item(OP_ADD, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA);
      for (int i = 0; i < 700; i++) begin
         den_a = pick_value();
         den_b = pick_value();
         if ($urandom_range(0, 19) != 0 && den_a == 0) den_a = 32'd7;
         if ($urandom_range(0, 19) != 0 && den_b == 0) den_b = 32'd3;
         queue_item($urandom_range(0, 15) == 0 ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4)),
                    pick_value(), den_a, pick_value(), den_b);
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_gap <= 0;
      end else if (req_valid && !req_ready) begin
      end else if (req_gap > 0) begin
         req_valid <= 1'b0;
         req_gap <= req_gap - 1;
      end else if (pending_reqs.size() > 0) begin
         req_data <= pending_reqs[0];
         expected_rsps.push_back(rational_result(pending_reqs[0]));
         void'(pending_reqs.pop_front());
         req_valid <= 1'b1;
         req_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
      end else begin
         req_valid <= 1'b0;
         stim_done <= !req_valid || req_ready;
      end
   end

   // long receiver stall
   always @(posedge clock) begin
      if (reset) begin
         hold_off <= 0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
      end else if (n_checked == 300 && rsp_ready && rsp_valid) begin
         hold_off <= 2000;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response %p", $time, rsp_data);
               errors <= errors + 1;
            end else begin
               if (rsp_data !== expected_rsps[0]) begin
                  $display("%0t: mismatch expected %p actual %p", $time,
                           expected_rsps[0], rsp_data);
                  errors <= errors + 1;
               end
               n_status[expected_rsps[0].status] <= n_status[expected_rsps[0].status] + 1;
               void'(expected_rsps.pop_front());
            end
            n_checked <= n_checked + 1;
         end
         if (hold_off > 0) begin
            rsp_ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_ready <= 1'b0;
            rsp_gap <= rsp_gap - 1;
         end else if (rsp_valid && rsp_ready) begin
            rsp_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      cycles = 0;
      while (!(stim_done && expected_rsps.size() == 0) && cycles < MAX_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      if (cycles >= MAX_CYCLES) begin
         $display("Some tests failed");
         $finish;
      end
      repeat (250) @(posedge clock);
      $display("Checked %0d results: %0d ok, %0d zero denominator, %0d division by zero,",
               n_checked, n_status[0], n_status[1], n_status[2]);
      $display("%0d overflow, over %0d cycles", n_status[3], cycles);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
